// ===== hw/rtl/binary_grid_3x3_count_assert.svh =====
// ----------------------------------------------------------------------------
// binary_grid_3x3_count assertion macros
// Shared concurrent check forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_GRID_3X3_COUNT_ASSERT_SVH
`define BINARY_GRID_3X3_COUNT_ASSERT_SVH

// Same-cycle implication.
`define BG3C_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bg3c: same-cycle check failed");

// Next-cycle implication.
`define BG3C_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bg3c: next-cycle check failed");

`endif

// ===== hw/rtl/bg3c_pkg.sv =====
// ----------------------------------------------------------------------------
// bg3c_pkg
// Field widths, register indexes and shared types of the 3x3 mark counter.
// ----------------------------------------------------------------------------
package bg3c_pkg;

    // Port field widths
    localparam int CELL_CHAR_W   = 8;
    localparam int MARK_COUNT_W  = 4;
    localparam int CELL_COL_W    = 5;
    localparam int CELL_ROW_W    = 12;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 12;
    localparam int GRID_WIDTH_W  = 6;
    localparam int GRID_HEIGHT_W = 12;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    // Register reset values
    localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 6'd32;
    localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 12'd32;

    // A cell is marked when its byte is 'M'
    localparam logic [CELL_CHAR_W-1:0] MARK_BYTE = 8'd77;

    // Largest window count
    localparam logic [MARK_COUNT_W-1:0] MAX_COUNT = 4'd9;

    typedef logic [MARK_COUNT_W-1:0] count_t;

    // One column of the window: row above, center row, row below
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } col3_t;

    // Window control from the sequencer
    typedef struct packed {
        logic shift;      // load a new right-hand column
        logic has_above;  // row above the center exists
        logic has_below;  // row below the center exists
        logic left_a;     // left column exists for the trailing-center count
        logic left_b;     // left column exists for the right-edge count
    } win_ctl_t;

endpackage

// ===== hw/rtl/bg3c_ram.sv =====
// ----------------------------------------------------------------------------
// bg3c_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bg3c_ram #(
    parameter int DATA_W = 2,
    parameter int DEPTH  = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                      wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                      rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bg3c_window.sv =====
// ----------------------------------------------------------------------------
// bg3c_window
// Three-column sliding window and the two 3x3 counts taken from it.
// ----------------------------------------------------------------------------
module bg3c_window (
    input  logic              aclk,
    input  bg3c_pkg::win_ctl_t ctl,
    input  bg3c_pkg::col3_t    col_new,
    output bg3c_pkg::count_t   count_a,
    output bg3c_pkg::count_t   count_b
);
    import bg3c_pkg::*;

    col3_t win_l_reg;
    col3_t win_m_reg;
    col3_t win_r_reg;

    logic [1:0] sum_l;
    logic [1:0] sum_m;
    logic [1:0] sum_r;

    // Marks in one column, rows outside the grid left out
    function automatic logic [1:0] col_sum(col3_t c, logic above, logic below);
        logic [1:0] s;
        s = {1'b0, c.mid} + {1'b0, c.top & above} + {1'b0, c.bot & below};
        return s;
    endfunction

    // Advance the window by one column
    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            win_l_reg <= win_m_reg;
            win_m_reg <= win_r_reg;
            win_r_reg <= col_new;
        end
    end

    assign sum_l = col_sum(win_l_reg, ctl.has_above, ctl.has_below);
    assign sum_m = col_sum(win_m_reg, ctl.has_above, ctl.has_below);
    assign sum_r = col_sum(win_r_reg, ctl.has_above, ctl.has_below);

    // Center on the middle column, or on the right column at the row's end
    assign count_a = (ctl.left_a ? MARK_COUNT_W'(sum_l) : '0)
                   + MARK_COUNT_W'(sum_m) + MARK_COUNT_W'(sum_r);
    assign count_b = (ctl.left_b ? MARK_COUNT_W'(sum_m) : '0) + MARK_COUNT_W'(sum_r);

endmodule

// ===== hw/rtl/binary_grid_3x3_count.sv =====
// ----------------------------------------------------------------------------
// binary_grid_3x3_count
// Counts marked cells ('M') in the 3x3 window of every cell of a raster grid.
//
//   channel   dir   handshake            payload
//   s_        in    s_valid / s_ready    s_cell_char
//   m_        out   m_valid / m_ready    m_mark_count, m_cell_col, m_cell_row,
//                                        m_frame_last
//   cfg_      in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One cell at a time: a cell is taken in the idle state, its column of the
// store is read and then written back, and one emit state runs per result
// (two results at a row's last column). The last cell of a frame adds a
// flush sweep of the store, column by column. A stalled m_ready holds the
// sequencer in its emit state. Reset sets width and height to 32 and starts
// a new frame; the column store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "binary_grid_3x3_count_assert.svh"

module binary_grid_3x3_count #(
    parameter int MAX_WIDTH = 32,
    parameter int ROW_BITS  = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bg3c_pkg::CELL_CHAR_W-1:0]   s_cell_char,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bg3c_pkg::MARK_COUNT_W-1:0]  m_mark_count,
    output logic [bg3c_pkg::CELL_COL_W-1:0]    m_cell_col,
    output logic [bg3c_pkg::CELL_ROW_W-1:0]    m_cell_row,
    output logic                               m_frame_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bg3c_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bg3c_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bg3c_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCMP_W = GRID_WIDTH_W + 1;
    localparam int HCMP_W = ((ROW_BITS > GRID_HEIGHT_W) ? ROW_BITS : GRID_HEIGHT_W) + 1;
    localparam logic [HCMP_W-1:0] HMAX = HCMP_W'((64'd1 << ROW_BITS) - 64'd1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_EMIT_A = 3'd2;
    localparam logic [2:0] ST_EMIT_B = 3'd3;
    localparam logic [2:0] ST_FL_ADR = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [GRID_WIDTH_W-1:0]  cfg_width_reg, cfg_width_next;
    logic [GRID_HEIGHT_W-1:0] cfg_height_reg, cfg_height_next;
    logic [COL_W-1:0]         in_col_reg, in_col_next;
    logic [ROW_BITS-1:0]      in_row_reg, in_row_next;
    logic                     flush_reg, flush_next;
    logic [COL_W-1:0]         job_col_reg, job_col_next;
    logic [ROW_BITS-1:0]      job_row_reg, job_row_next;
    logic                     job_vis_reg, job_vis_next;
    logic                     job_mark_reg, job_mark_next;
    logic                     job_end_reg, job_end_next;
    logic                     job_b_reg, job_b_next;
    logic                     m_valid_reg, m_valid_next;
    count_t                   m_count_reg, m_count_next;
    logic [CELL_COL_W-1:0]    m_col_reg, m_col_next;
    logic [CELL_ROW_W-1:0]    m_row_reg, m_row_next;
    logic                     m_last_reg, m_last_next;

    logic [WCMP_W-1:0] w_raw, eff_w;
    logic [HCMP_W-1:0] h_raw, eff_h;
    logic [COL_W-1:0]  last_col;
    logic [ROW_BITS-1:0] last_row;
    logic [COL_W-1:0]  col_prev;
    logic              s_accept, cfg_accept, out_free, need_a, need_b;

    logic [2:0]          adv_state;
    logic [COL_W-1:0]    adv_col;
    logic [ROW_BITS-1:0] adv_row;
    logic                adv_flush, adv_vis;

    logic             ram_we, ram_re;
    logic [COL_W-1:0] ram_waddr, ram_raddr;
    logic [1:0]       ram_wdata, ram_rdata;

    win_ctl_t win_ctl;
    col3_t    col_new;
    count_t   count_a, count_b;

    // Clamp the configured frame size
    always_comb begin
        w_raw = WCMP_W'(cfg_width_reg);
        if (w_raw == '0) begin
            eff_w = WCMP_W'(1);
        end else if (w_raw > WCMP_W'(MAX_WIDTH)) begin
            eff_w = WCMP_W'(MAX_WIDTH);
        end else begin
            eff_w = w_raw;
        end
        h_raw = HCMP_W'(cfg_height_reg);
        if (h_raw == '0) begin
            eff_h = HCMP_W'(1);
        end else if (h_raw > HMAX) begin
            eff_h = HMAX;
        end else begin
            eff_h = h_raw;
        end
    end

    assign last_col = COL_W'(eff_w - WCMP_W'(1));
    assign last_row = ROW_BITS'(eff_h - HCMP_W'(1));
    assign col_prev = job_col_reg - COL_W'(1);

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign s_accept   = s_valid & s_ready;
    assign cfg_accept = cfg_valid & cfg_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign need_a     = job_vis_reg && (job_col_reg != '0);
    assign need_b     = job_vis_reg && (job_col_reg == last_col);

    // Column store: {row two above, row just above} per column
    bg3c_ram #(
        .DATA_W (2),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign col_new = '{top: ram_rdata[1], mid: ram_rdata[0],
                       bot: job_mark_reg & !flush_reg};

    assign win_ctl.shift     = (state_reg == ST_READ);
    assign win_ctl.has_above = (job_row_reg != '0);
    assign win_ctl.has_below = !flush_reg;
    assign win_ctl.left_a    = (job_col_reg > COL_W'(1));
    assign win_ctl.left_b    = (job_col_reg != '0);

    bg3c_window u_window (
        .aclk    (aclk),
        .ctl     (win_ctl),
        .col_new (col_new),
        .count_a (count_a),
        .count_b (count_b)
    );

    // Pick what follows the results of the current column
    always_comb begin
        adv_state = ST_IDLE;
        adv_col   = job_col_reg;
        adv_row   = job_row_reg;
        adv_flush = flush_reg;
        adv_vis   = job_vis_reg;
        if (flush_reg) begin
            if (job_col_reg == last_col) begin
                adv_flush = 1'b0;
            end else begin
                adv_state = ST_FL_ADR;
                adv_col   = job_col_reg + COL_W'(1);
            end
        end else if (job_end_reg) begin
            adv_state = ST_FL_ADR;
            adv_col   = '0;
            adv_row   = job_row_reg + ROW_BITS'(1);
            adv_flush = 1'b1;
            adv_vis   = 1'b1;
        end
    end

    // Sequencer: read, write back, emit, flush
    always_comb begin
        state_next      = state_reg;
        cfg_width_next  = cfg_width_reg;
        cfg_height_next = cfg_height_reg;
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        flush_next      = flush_reg;
        job_col_next    = job_col_reg;
        job_row_next    = job_row_reg;
        job_vis_next    = job_vis_reg;
        job_mark_next   = job_mark_reg;
        job_end_next    = job_end_reg;
        job_b_next      = job_b_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_count_next    = m_count_reg;
        m_col_next      = m_col_reg;
        m_row_next      = m_row_reg;
        m_last_next     = m_last_reg;
        ram_re          = 1'b0;
        ram_raddr       = in_col_reg;
        ram_we          = 1'b0;
        ram_waddr       = job_col_reg;
        ram_wdata       = {ram_rdata[0], job_mark_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    ram_re        = 1'b1;
                    job_col_next  = in_col_reg;
                    job_row_next  = in_row_reg - ROW_BITS'(1);
                    job_vis_next  = (in_row_reg != '0);
                    job_mark_next = (s_cell_char == MARK_BYTE);
                    job_end_next  = 1'b0;
                    state_next    = ST_READ;
                    if (in_col_reg == last_col) begin
                        in_col_next = '0;
                        if (in_row_reg == last_row) begin
                            in_row_next  = '0;
                            job_end_next = 1'b1;
                        end else begin
                            in_row_next = in_row_reg + ROW_BITS'(1);
                        end
                    end else begin
                        in_col_next = in_col_reg + COL_W'(1);
                    end
                end
            end
            ST_READ: begin
                // Shift the column history down; flush only reads
                ram_we     = !flush_reg;
                job_b_next = need_b;
                if (need_a) begin
                    state_next = ST_EMIT_A;
                end else if (need_b) begin
                    state_next = ST_EMIT_B;
                end else begin
                    state_next   = adv_state;
                    job_col_next = adv_col;
                    job_row_next = adv_row;
                    flush_next   = adv_flush;
                    job_vis_next = adv_vis;
                end
            end
            ST_EMIT_A: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_count_next = count_a;
                    m_col_next   = CELL_COL_W'(col_prev);
                    m_row_next   = CELL_ROW_W'(job_row_reg);
                    m_last_next  = 1'b0;
                    if (job_b_reg) begin
                        state_next = ST_EMIT_B;
                    end else begin
                        state_next   = adv_state;
                        job_col_next = adv_col;
                        job_row_next = adv_row;
                        flush_next   = adv_flush;
                        job_vis_next = adv_vis;
                    end
                end
            end
            ST_EMIT_B: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_count_next = count_b;
                    m_col_next   = CELL_COL_W'(job_col_reg);
                    m_row_next   = CELL_ROW_W'(job_row_reg);
                    m_last_next  = flush_reg;
                    state_next   = adv_state;
                    job_col_next = adv_col;
                    job_row_next = adv_row;
                    flush_next   = adv_flush;
                    job_vis_next = adv_vis;
                end
            end
            ST_FL_ADR: begin
                ram_re     = 1'b1;
                ram_raddr  = job_col_reg;
                state_next = ST_READ;
            end
            default: begin
                state_next = ST_IDLE;
                flush_next = 1'b0;
            end
        endcase

        // A write to the width or height register restarts the frame
        if (cfg_accept) begin
            unique case (cfg_index)
                REG_GRID_WIDTH: begin
                    cfg_width_next = GRID_WIDTH_W'(cfg_data);
                    in_col_next    = '0;
                    in_row_next    = '0;
                end
                REG_GRID_HEIGHT: begin
                    cfg_height_next = GRID_HEIGHT_W'(cfg_data);
                    in_col_next     = '0;
                    in_row_next     = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cfg_width_reg  <= GRID_WIDTH_RST;
            cfg_height_reg <= GRID_HEIGHT_RST;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            flush_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cfg_width_reg  <= cfg_width_next;
            cfg_height_reg <= cfg_height_next;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            flush_reg      <= flush_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Job and result payload
    always_ff @(posedge aclk) begin
        job_col_reg  <= job_col_next;
        job_row_reg  <= job_row_next;
        job_vis_reg  <= job_vis_next;
        job_mark_reg <= job_mark_next;
        job_end_reg  <= job_end_next;
        job_b_reg    <= job_b_next;
        m_count_reg  <= m_count_next;
        m_col_reg    <= m_col_next;
        m_row_reg    <= m_row_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_mark_count = m_count_reg;
    assign m_cell_col   = m_col_reg;
    assign m_cell_row   = m_row_reg;
    assign m_frame_last = m_last_reg;

    // Checks
    `BG3C_ASSERT_NXT(a_accept_reads, s_valid && s_ready, state_reg == ST_READ)
    `BG3C_ASSERT_IMP(a_count_range, m_valid, m_mark_count <= MAX_COUNT)
    `BG3C_ASSERT_IMP(a_last_at_edge, m_valid && m_frame_last, m_cell_col == CELL_COL_W'(last_col))
    `BG3C_ASSERT_IMP(a_no_write_in_flush, ram_we, !flush_reg && state_reg == ST_READ)

endmodule

// ===== dv/binary_grid_3x3_count_tb.sv =====
// ----------------------------------------------------------------------------
// binary_grid_3x3_count_tb
// Streams raster frames of cell bytes through the 3x3 mark counter under
// random source and sink stalls, predicts every window count, and checks
// each result in order. Covers the reset geometry, a short directed set
// (full and empty windows, bytes next to 'M', single-cell and single-column
// grids, zero and saturating register values), then random phases of
// complete and cut-off frames, including the widest grid and the tallest.
// ----------------------------------------------------------------------------
module binary_grid_3x3_count_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bg3c_pkg::*;

    localparam int GRID_COLS      = 32;
    localparam int CLK_HALF       = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;
    localparam int STALL_LIMIT    = 1000;
    localparam int RANDOM_CELLS   = 140;
    localparam int MAX_FULL_FRAME = 72;
    localparam int PRINT_LIMIT    = 40;

    // Indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 2'd3;

    typedef logic [GRID_COLS-1:0] mark_row_t;

    typedef struct {
        count_t                count;
        logic [CELL_COL_W-1:0] col;
        logic [CELL_ROW_W-1:0] row;
        logic                  last;
    } window_count_t;

    // ------------------------------------------------------------------------
    // Window count predictor and in-order result check
    // ------------------------------------------------------------------------
    class mark_count_board;
        logic [GRID_WIDTH_W-1:0]  width_reg;
        logic [GRID_HEIGHT_W-1:0] height_reg;
        mark_row_t                upper_row;
        mark_row_t                middle_row;
        mark_row_t                lower_row;
        int unsigned              next_col;
        int unsigned              next_row;
        window_count_t            expected_counts[$];
        int unsigned              errors;
        int unsigned              checked;
        int unsigned              frames;

        function new();
            width_reg  = GRID_WIDTH_RST;
            height_reg = GRID_HEIGHT_RST;
            errors     = 0;
            checked    = 0;
            frames     = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            upper_row  = '0;
            middle_row = '0;
            lower_row  = '0;
            next_col   = 0;
            next_row   = 0;
        endfunction

        function int unsigned active_width();
            if (width_reg == 0) return 1;
            if (width_reg > GRID_COLS) return GRID_COLS;
            return 32'(width_reg);
        endfunction

        function int unsigned active_height();
            if (height_reg == 0) return 1;
            return 32'(height_reg);
        endfunction

        // Marks at c-1, c, c+1 of one row, clipped at the grid edges
        function int unsigned row_span(mark_row_t marks, int unsigned c, int unsigned w);
            int unsigned s;
            s = 32'(marks[c]);
            if (c > 0) s += 32'(marks[c-1]);
            if (c + 1 < w) s += 32'(marks[c+1]);
            return s;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GRID_WIDTH: begin
                    width_reg = data[GRID_WIDTH_W-1:0];
                    restart_frame();
                end
                REG_GRID_HEIGHT: begin
                    height_reg = data[GRID_HEIGHT_W-1:0];
                    restart_frame();
                end
                default: ;
            endcase
        endfunction

        function void push_count(int unsigned count, int unsigned col, int unsigned row,
                                 logic last);
            window_count_t e;
            e.count = count[MARK_COUNT_W-1:0];
            e.col   = col[CELL_COL_W-1:0];
            e.row   = row[CELL_ROW_W-1:0];
            e.last  = last;
            expected_counts.push_back(e);
        endfunction

        // Take one accepted cell and queue the counts it completes
        function void note_cell(logic [CELL_CHAR_W-1:0] ch);
            int unsigned w, h, r, c, k, s;
            w = active_width();
            h = active_height();
            if (next_col >= w || next_row >= h) restart_frame();
            r = next_row;
            c = next_col;
            if (ch == MARK_BYTE) lower_row[c] = 1'b1;

            // Row above the input row is complete up to c
            if (r >= 1) begin
                if (c >= 1) begin
                    s = row_span(middle_row, c - 1, w) + row_span(lower_row, c - 1, w);
                    if (r > 1) s += row_span(upper_row, c - 1, w);
                    push_count(s, c - 1, r - 1, 1'b0);
                end
                if (c == w - 1) begin
                    s = row_span(middle_row, c, w) + row_span(lower_row, c, w);
                    if (r > 1) s += row_span(upper_row, c, w);
                    push_count(s, c, r - 1, 1'b0);
                end
            end

            // Flush the bottom row at the end of the frame
            if (c == w - 1 && r == h - 1) begin
                for (k = 0; k < w; k++) begin
                    s = row_span(lower_row, k, w);
                    if (r > 0) s += row_span(middle_row, k, w);
                    push_count(s, k, r, k == w - 1);
                end
                frames++;
                restart_frame();
            end else if (c == w - 1) begin
                upper_row  = middle_row;
                middle_row = lower_row;
                lower_row  = '0;
                next_col   = 0;
                next_row   = r + 1;
            end else begin
                next_col = c + 1;
            end
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t ns: MISMATCH %s got %0d expected %0d", $time, what, got, want);
        endtask

        task check_result(count_t count, logic [CELL_COL_W-1:0] col,
                          logic [CELL_ROW_W-1:0] row, logic last);
            window_count_t e;
            if (expected_counts.size() == 0) begin
                report("unexpected result, cell_col", 32'(col), 0);
                return;
            end
            e = expected_counts.pop_front();
            checked++;
            if (count !== e.count) report("mark_count", 32'(count), 32'(e.count));
            if (col !== e.col) report("cell_col", 32'(col), 32'(e.col));
            if (row !== e.row) report("cell_row", 32'(row), 32'(e.row));
            if (last !== e.last) report("frame_last", 32'(last), 32'(e.last));
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [CELL_CHAR_W-1:0]   s_cell_char;
    logic                     m_valid;
    logic                     m_ready;
    logic [MARK_COUNT_W-1:0]  m_mark_count;
    logic [CELL_COL_W-1:0]    m_cell_col;
    logic [CELL_ROW_W-1:0]    m_cell_row;
    logic                     m_frame_last;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    mark_count_board board = new();
    bit              steady_flow = 1'b0;
    int unsigned     cells_sent = 0;
    int unsigned     random_cells = 0;
    int unsigned     reg_writes = 0;
    int unsigned     quiet_cycles = 0;

    logic [CELL_CHAR_W-1:0] mixed_cells [9] = '{MARK_BYTE, 8'h00, 8'hFF, 8'h4C, MARK_BYTE,
                                                8'h4E, 8'hCD, 8'h6D, MARK_BYTE};

    binary_grid_3x3_count dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_char  (s_cell_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mark_count (m_mark_count),
        .m_cell_col   (m_cell_col),
        .m_cell_row   (m_cell_row),
        .m_frame_last (m_frame_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial aclk = 1'b0;
    always #(CLK_HALF) aclk = ~aclk;

    // Pick a cell byte: 'M' with the given percentage, else any byte
    function automatic logic [CELL_CHAR_W-1:0] pick_cell(int unsigned density);
        if ($urandom_range(0, 99) < density) return MARK_BYTE;
        return CELL_CHAR_W'($urandom_range(0, 255));
    endfunction

    // Offer one cell after a random gap and hold it until the transaction
    task automatic send_cell(logic [CELL_CHAR_W-1:0] ch);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cell_char <= ch;
        do @(posedge aclk); while (!s_ready);
        board.note_cell(ch);
        cells_sent++;
    endtask

    // Leave cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, data);
        reg_writes++;
    endtask

    task automatic program_grid(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata,
                                bit set_height);
        if (set_height && $urandom_range(0, 1)) begin
            write_reg(REG_GRID_HEIGHT, hdata);
            write_reg(REG_GRID_WIDTH, wdata);
        end else begin
            write_reg(REG_GRID_WIDTH, wdata);
            if (set_height) write_reg(REG_GRID_HEIGHT, hdata);
        end
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every pending count, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (board.expected_counts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Stream cells; optionally poke an unused register index halfway through
    task automatic stream_cells(int unsigned n, int unsigned density, bit spare_write);
        int unsigned i;
        for (i = 0; i < n; i++) begin
            if (spare_write && i == n / 2) begin
                drain();
                write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                          CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
                cfg_valid <= 1'b0;
            end
            send_cell(pick_cell(density));
        end
        drain();
    endtask

    task automatic random_phase();
        logic [CFG_DATA_W-1:0] wdata, hdata;
        int unsigned frame, n;
        case ($urandom_range(0, 9))
            0:       wdata = 0;
            1:       wdata = CFG_DATA_W'($urandom_range(GRID_COLS + 1,
                                                         (1 << GRID_WIDTH_W) - 1));
            2:       wdata = CFG_DATA_W'(GRID_COLS);
            default: wdata = CFG_DATA_W'($urandom_range(1, 6));
        endcase
        // Upper data bits do not belong to the width register
        wdata[CFG_DATA_W-1:GRID_WIDTH_W] = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 9))
            0:       hdata = 0;
            1:       hdata = CFG_DATA_W'((1 << GRID_HEIGHT_W) - 1);
            2:       hdata = CFG_DATA_W'($urandom_range(5, 12));
            default: hdata = CFG_DATA_W'($urandom_range(1, 4));
        endcase
        steady_flow = ($urandom_range(0, 3) == 0);
        program_grid(wdata, hdata, $urandom_range(0, 3) != 0);

        frame = board.active_width() * board.active_height();
        if (frame > MAX_FULL_FRAME) n = $urandom_range(20, 60);
        else if (frame > 1 && $urandom_range(0, 4) == 0) n = $urandom_range(1, frame - 1);
        else n = frame * $urandom_range(1, 2);
        stream_cells(n, $urandom_range(0, 4) * 25, n >= 2 && $urandom_range(0, 3) == 0);
        random_cells += n;
    endtask

    // Result sink with random stalls
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_result(m_mark_count, m_cell_col, m_cell_row, m_frame_last);
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d idle cycles, %0d counts pending",
                         quiet_cycles, board.expected_counts.size());
                $display("binary_grid_3x3_count test failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned i;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_cell_char = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_GRID_WIDTH;
        cfg_data    = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: a cut-off 32x32 frame
        stream_cells(40, 50, 1'b0);

        // Every window full, then bytes around 'M'
        program_grid(3, 3, 1'b1);
        for (i = 0; i < 9; i++) send_cell(MARK_BYTE);
        drain();
        for (i = 0; i < 9; i++) send_cell(mixed_cells[i]);
        drain();

        // Single-cell frames, then zero registers that act as one
        program_grid(1, 1, 1'b1);
        send_cell(MARK_BYTE);
        send_cell(8'h00);
        drain();
        program_grid(0, 0, 1'b1);
        send_cell(MARK_BYTE);
        drain();

        // Single column
        program_grid(1, 3, 1'b1);
        send_cell(MARK_BYTE);
        send_cell(8'hB2);
        send_cell(MARK_BYTE);
        drain();

        // Widest grid over two rows: the longest burst of counts
        program_grid({6'($urandom_range(0, 63)), 6'($urandom_range(GRID_COLS, 63))}, 2, 1'b1);
        stream_cells(2 * GRID_COLS, 40, 1'b0);
        random_cells += 2 * GRID_COLS;

        // Tallest grid, cut off
        program_grid(CFG_DATA_W'($urandom_range(1, GRID_COLS)),
                     CFG_DATA_W'((1 << GRID_HEIGHT_W) - 1), 1'b1);
        stream_cells(50, 50, 1'b0);
        random_cells += 50;

        while (random_cells < RANDOM_CELLS) random_phase();

        steady_flow = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.expected_counts.size() != 0)
            board.report("counts left over", board.expected_counts.size(), 0);

        $display("Sent %0d cells (%0d random) over %0d complete frames, %0d register writes",
                 cells_sent, random_cells, board.frames, reg_writes);
        $display("Checked %0d window counts, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0) begin
            $display("binary_grid_3x3_count test passed");
        end else begin
            $display("binary_grid_3x3_count test failed");
        end
        $finish;
    end

endmodule
